[rtl/hbp_pkg.sv]
// shared types and constants of the huffman bit packer
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int CMD_W            = 2;
    localparam int ENTRY_W          = 9;
    localparam int SYMBOL_W         = 8;
    localparam int CODE_BITS_W      = 32;
    localparam int CODE_LEN_W       = 6;
    localparam int BYTE_W           = 8;
    localparam int BYTE_SH          = $clog2(BYTE_W);
    localparam int TABLE_DEPTH      = 257;
    localparam int FILL_W           = 3;

    localparam logic [ENTRY_W-1:0] EOF_ENTRY = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic              fin;
        logic [FILL_W-1:0] count;
    } emit_req_t;

endpackage
`default_nettype wire

[rtl/hbp_if.sv]
// valid/ready channel interfaces for input and output words
`timescale 1ns / 1ps
`default_nettype none
interface hbp_in_if;
    import hbp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [ENTRY_W-1:0]     entry_index;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_len;

    modport source (
        output valid, command, entry_index, symbol, code_bits, code_len,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, symbol, code_bits, code_len,
        output ready
    );
endinterface

interface hbp_out_if;
    import hbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;

    modport source (
        output valid, out_byte, run_last, stream_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, run_last, stream_end,
        output ready
    );
endinterface
`default_nettype wire

[rtl/hbp_emitter.sv]
// byte emitter: holds up to one item's bytes, sends one per cycle if ready
`timescale 1ns / 1ps
`default_nettype none
module hbp_emitter #(
    parameter int BUF_W = 40
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hbp_pkg::emit_req_t req,
    input  wire logic [BUF_W-1:0]   req_bytes,
    output logic                    req_ready,
    hbp_out_if.source               dout
);
    import hbp_pkg::*;

    logic [BUF_W-1:0]  buf_reg;
    logic [FILL_W-1:0] left_reg;
    logic              fin_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              stream_end_reg;
    logic              shift_go;
    logic              last_one;

    assign last_one  = (left_reg == FILL_W'(1));
    assign shift_go  = (left_reg != '0) && (!out_valid_reg || dout.ready);
    assign req_ready = (left_reg == '0) || (last_one && shift_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid)
                left_reg <= req.count;
            else if (shift_go)
                left_reg <= left_reg - FILL_W'(1);

            if (shift_go)
                out_valid_reg <= 1'b1;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            buf_reg <= req_bytes;
            fin_reg <= req.fin;
        end
        else if (shift_go)
        begin
            buf_reg <= buf_reg >> BYTE_W;
        end

        if (shift_go)
        begin
            out_byte_reg   <= buf_reg[BYTE_W-1:0];
            run_last_reg   <= last_one;
            stream_end_reg <= last_one && fin_reg;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.out_byte   = out_byte_reg;
    assign dout.run_last   = run_last_reg;
    assign dout.stream_end = stream_end_reg;

endmodule
`default_nettype wire

[rtl/huffman_bit_packer.sv]
// huffman bit packer top level: code table memory, bit accumulator, byte emitter
//
// Load words write one entry of a 257-entry code table (bytes 0..255 and the
// end-of-file code at 256); the table is a single memory with one write and
// one registered read port and needs no clearing after reset, but entries
// must be loaded before they are used. Encode and finish words read their
// entry in the accept cycle, merge it with the pending bits in the next, and
// hand the completed bytes to an output stage that sends one byte per cycle
// while the output is ready. An encode produces at most 4 bytes and a finish
// at most 5 with 32-bit codes; the first byte passes the registered table
// read, the merge stage, and the emitter's buffer and output registers.
// A new word is taken while earlier bytes drain.
`timescale 1ns / 1ps
`default_nettype none
module huffman_bit_packer #(
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hbp_in_if.sink    din,
    hbp_out_if.source dout
);
    import hbp_pkg::*;

    localparam int CODE_W     = (MAX_CODE_LEN > CODE_BITS_W) ? CODE_BITS_W : MAX_CODE_LEN;
    localparam int LEN_W      = $clog2(CODE_W + 1);
    localparam int ACC_W      = CODE_W + BYTE_W - 1;
    localparam int T_W        = $clog2(ACC_W + BYTE_W);
    localparam int BYTES_MAX  = (ACC_W + BYTE_W - 1) / BYTE_W;
    localparam int BUF_W      = BYTES_MAX * BYTE_W;
    localparam int PAD_W      = (ACC_W / BYTE_W + 1) * BYTE_W;
    localparam int ENTRY_BITS = LEN_W + CODE_W;

    // table entry: length above, code bits stored in send order below
    logic [ENTRY_BITS-1:0]  code_mem [TABLE_DEPTH];
    logic [ENTRY_BITS-1:0]  rd_data_reg;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_fin_reg;
    logic                   s1_fin_next;
    logic [BYTE_W-2:0]      pend_bits_reg;
    logic [BYTE_W-2:0]      pend_bits_next;
    logic [BYTE_SH-1:0]     pend_cnt_reg;
    logic [BYTE_SH-1:0]     pend_cnt_next;

    cmd_t                   cmd;
    logic                   in_fire;
    logic                   wr_en;
    logic                   rd_en;
    logic [ENTRY_W-1:0]     rd_addr;
    logic [LEN_W-1:0]       load_len;
    logic [CODE_BITS_W-1:0] code_rev;
    logic [CODE_BITS_W-1:0] code_order;

    logic [LEN_W-1:0]       rd_len;
    logic [CODE_W-1:0]      rd_code;
    logic [T_W-1:0]         total;
    logic [T_W-1:0]         full_bytes;
    logic [T_W-1:0]         fin_bytes;
    logic [ACC_W-1:0]       combined;
    logic [PAD_W-1:0]       rest;
    logic [FILL_W-1:0]      emit_count;
    logic                   need_emit;
    logic                   s1_go;
    logic                   em_ready;
    emit_req_t              em_req;

    assign cmd     = cmd_t'(din.command);
    assign in_fire = din.valid && din.ready;

    // load path: clamp length, put first-sent bit at bit 0
    always_comb
    begin
        if (din.code_len > CODE_LEN_W'(CODE_W))
            load_len = LEN_W'(CODE_W);
        else
            load_len = LEN_W'(din.code_len);
        for (int j = 0; j < CODE_BITS_W; j++)
            code_rev[j] = din.code_bits[CODE_BITS_W-1-j];
        code_order = code_rev >> (CODE_LEN_W'(CODE_BITS_W) - CODE_LEN_W'(load_len));
    end

    always_comb
    begin
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = EOF_ENTRY;
        case (cmd)
            CMD_LOAD:
            begin
                wr_en = in_fire && (din.entry_index <= EOF_ENTRY);
            end
            CMD_ENCODE:
            begin
                rd_en   = in_fire;
                rd_addr = ENTRY_W'(din.symbol);
            end
            CMD_FINISH:
            begin
                rd_en = in_fire;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            code_mem[din.entry_index] <= {load_len, code_order[CODE_W-1:0]};
        if (rd_en)
            rd_data_reg <= code_mem[rd_addr];
    end

    // merge stage
    assign rd_len  = rd_data_reg[ENTRY_BITS-1:CODE_W];
    assign rd_code = rd_data_reg[CODE_W-1:0];

    always_comb
    begin
        total      = T_W'(pend_cnt_reg) + T_W'(rd_len);
        combined   = ACC_W'(pend_bits_reg) | (ACC_W'(rd_code) << pend_cnt_reg);
        full_bytes = total >> BYTE_SH;
        if (total == '0)
            fin_bytes = T_W'(1);
        else
            fin_bytes = (total + T_W'(BYTE_W - 1)) >> BYTE_SH;
        rest       = PAD_W'(combined) >> {full_bytes, {BYTE_SH{1'b0}}};
        if (s1_fin_reg)
            emit_count = FILL_W'(fin_bytes);
        else
            emit_count = FILL_W'(full_bytes);
        need_emit  = (emit_count != '0);
        s1_go      = s1_valid_reg && (!need_emit || em_ready);
    end

    assign din.ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        em_req.valid = s1_go && need_emit;
        em_req.fin   = s1_fin_reg;
        em_req.count = emit_count;

        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (s1_go)
        begin
            if (s1_fin_reg)
            begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            else
            begin
                pend_bits_next = rest[BYTE_W-2:0];
                pend_cnt_next  = total[BYTE_SH-1:0];
            end
        end

        s1_valid_next = s1_valid_reg;
        s1_fin_next   = s1_fin_reg;
        if (din.ready)
        begin
            s1_valid_next = rd_en;
            s1_fin_next   = (cmd == CMD_FINISH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_fin_reg    <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_fin_reg    <= s1_fin_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    hbp_emitter #(
        .BUF_W (BUF_W)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (em_req),
        .req_bytes (BUF_W'(combined)),
        .req_ready (em_ready),
        .dout      (dout)
    );

endmodule
`default_nettype wire
